### rtl/sri_pkg.sv
// Shared types, constants and decode helpers for the six-register instruction executor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sri_pkg;

    // register file geometry
    localparam int          NUM_REGS   = 6;
    localparam int          REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [31:0] NUM_REGS_U = 32'(NUM_REGS);
    localparam int          DATA_W     = 64;

    // configuration register indexes
    localparam logic CFG_POINTER_REGISTER = 1'b0;
    localparam logic CFG_PROGRAM_LENGTH   = 1'b1;

    // widths of the stream words
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 136;

    // instruction set
    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } op_t;

    // write-back control from the execute stage to the register file
    typedef struct packed {
        logic                 fire;
        logic                 wr_en;
        logic [REG_IDX_W-1:0] wr_idx;
        logic                 ptr_en;
        logic [REG_IDX_W-1:0] ptr_idx;
    } commit_t;

    // operand A names a register
    function automatic logic reads_a_reg(input op_t op);
        logic r;
        case (op)
            OP_GTIR, OP_EQIR, OP_SETI: r = 1'b0;
            default:                   r = 1'b1;
        endcase
        return r;
    endfunction

    // operand B names a register
    function automatic logic reads_b_reg(input op_t op);
        logic r;
        case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
            OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: r = 1'b1;
            default:                            r = 1'b0;
        endcase
        return r;
    endfunction

    // multiply opcodes, which use the registered multiplier
    function automatic logic is_mul(input op_t op);
        return (op == OP_MULR) || (op == OP_MULI);
    endfunction

endpackage

`default_nettype wire

### rtl/sri_regfile.sv
// Register file of NUM_REGS 64-bit registers with result write and pointer increment.
// Depends on sri_pkg for geometry and the commit_t control struct.
`default_nettype none

module sri_regfile (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [sri_pkg::REG_IDX_W-1:0] rd_a_idx,
    input  wire logic [sri_pkg::REG_IDX_W-1:0] rd_b_idx,
    output logic      [sri_pkg::DATA_W-1:0]    rd_a_data,
    output logic      [sri_pkg::DATA_W-1:0]    rd_b_data,
    input  sri_pkg::commit_t                   commit,
    input  wire logic [sri_pkg::DATA_W-1:0]    wr_data,
    output logic      [sri_pkg::DATA_W-1:0]    ptr_value
);
    import sri_pkg::*;

    logic [DATA_W-1:0] regs_reg  [NUM_REGS];
    logic [DATA_W-1:0] regs_next [NUM_REGS];
    logic [DATA_W-1:0] ptr_base;

    // read ports
    assign rd_a_data = regs_reg[rd_a_idx];
    assign rd_b_data = regs_reg[rd_b_idx];

    // pointer sees the result first when it is also the destination
    always_comb begin
        if (commit.wr_en && (commit.wr_idx == commit.ptr_idx)) begin
            ptr_base = wr_data;
        end else begin
            ptr_base = regs_reg[commit.ptr_idx];
        end
        ptr_value = ptr_base + DATA_W'(1);
    end

    // next contents
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            regs_next[i] = regs_reg[i];
            if (commit.fire) begin
                if (commit.wr_en && (commit.wr_idx == REG_IDX_W'(i))) begin
                    regs_next[i] = wr_data;
                end
                if (commit.ptr_en && (commit.ptr_idx == REG_IDX_W'(i))) begin
                    regs_next[i] = ptr_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_REGS; i++) begin
            if (!aresetn) begin
                regs_reg[i] <= '0;
            end else begin
                regs_reg[i] <= regs_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sri_mul.sv
// 64-bit wrapping multiplier built from 32x32 partial products that are registered before the final sum.
// Depends on sri_pkg for the data width.
`default_nettype none

module sri_mul (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [sri_pkg::DATA_W-1:0] mul_a,
    input  wire logic [sri_pkg::DATA_W-1:0] mul_b,
    output logic      [sri_pkg::DATA_W-1:0] product
);
    import sri_pkg::*;

    localparam int HALF_W = DATA_W / 2;

    logic [DATA_W-1:0] pp_low_reg;
    logic [HALF_W-1:0] pp_cross_reg;
    logic [HALF_W-1:0] cross_a;
    logic [HALF_W-1:0] cross_b;

    // cross terms only matter in their low half
    assign cross_a = mul_a[HALF_W-1:0] * mul_b[DATA_W-1:HALF_W];
    assign cross_b = mul_a[DATA_W-1:HALF_W] * mul_b[HALF_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            pp_low_reg   <= mul_a[HALF_W-1:0] * mul_b[HALF_W-1:0];
            pp_cross_reg <= cross_a + cross_b;
        end
    end

    // final sum of the registered partial products
    assign product = pp_low_reg + {pp_cross_reg, {HALF_W{1'b0}}};

endmodule

`default_nettype wire

### rtl/sri_alu.sv
// Operand decode, index checks and result selection for one instruction.
// Depends on sri_pkg for opcodes and decode helpers; the product comes from sri_mul.
`default_nettype none

module sri_alu (
    input  sri_pkg::op_t                    op,
    input  wire logic [31:0]                operand_a,
    input  wire logic [31:0]                operand_b,
    input  wire logic [2:0]                 operand_c,
    input  wire logic [sri_pkg::DATA_W-1:0] rd_a_data,
    input  wire logic [sri_pkg::DATA_W-1:0] rd_b_data,
    input  wire logic [sri_pkg::DATA_W-1:0] mul_product,
    output logic      [sri_pkg::DATA_W-1:0] mul_a,
    output logic      [sri_pkg::DATA_W-1:0] mul_b,
    output logic      [sri_pkg::DATA_W-1:0] result,
    output logic      [2:0]                 dest,
    output logic                            bad
);
    import sri_pkg::*;

    logic              use_a;
    logic              use_b;
    logic              a_ok;
    logic              b_ok;
    logic              c_ok;
    logic [DATA_W-1:0] ra;
    logic [DATA_W-1:0] rb;
    logic [DATA_W-1:0] ia;
    logic [DATA_W-1:0] ib;
    logic [DATA_W-1:0] raw_res;

    // operand fetch and range checks
    always_comb begin
        use_a = reads_a_reg(op);
        use_b = reads_b_reg(op);
        a_ok  = operand_a < NUM_REGS_U;
        b_ok  = operand_b < NUM_REGS_U;
        c_ok  = {29'd0, operand_c} < NUM_REGS_U;
        ra    = (use_a && a_ok) ? rd_a_data : '0;
        rb    = (use_b && b_ok) ? rd_b_data : '0;
        ia    = {{(DATA_W-32){operand_a[31]}}, operand_a};
        ib    = {{(DATA_W-32){operand_b[31]}}, operand_b};
        bad   = (use_a && !a_ok) || (use_b && !b_ok) || !c_ok;
        mul_a = ra;
        mul_b = (op == OP_MULR) ? rb : ib;
    end

    // operation select
    always_comb begin
        case (op)
            OP_ADDR: raw_res = ra + rb;
            OP_ADDI: raw_res = ra + ib;
            OP_MULR: raw_res = mul_product;
            OP_MULI: raw_res = mul_product;
            OP_BANR: raw_res = ra & rb;
            OP_BANI: raw_res = ra & ib;
            OP_BORR: raw_res = ra | rb;
            OP_BORI: raw_res = ra | ib;
            OP_SETR: raw_res = ra;
            OP_SETI: raw_res = ia;
            OP_GTIR: raw_res = {{(DATA_W-1){1'b0}}, $signed(ia) > $signed(rb)};
            OP_GTRI: raw_res = {{(DATA_W-1){1'b0}}, $signed(ra) > $signed(ib)};
            OP_GTRR: raw_res = {{(DATA_W-1){1'b0}}, $signed(ra) > $signed(rb)};
            OP_EQIR: raw_res = {{(DATA_W-1){1'b0}}, ia == rb};
            OP_EQRI: raw_res = {{(DATA_W-1){1'b0}}, ra == ib};
            OP_EQRR: raw_res = {{(DATA_W-1){1'b0}}, ra == rb};
            default: raw_res = '0;
        endcase
        result = bad ? '0 : raw_res;
        dest   = bad ? 3'd0 : operand_c;
    end

endmodule

`default_nettype wire

### rtl/six_register_instruction_executor.sv
// Top level of the six-register instruction executor: input register, execute, result register.
// Depends on sri_pkg, sri_regfile, sri_mul and sri_alu.
//
// Each input word is one instruction run against NUM_REGS signed 64-bit registers; each
// produces exactly one result word. An accepted word sits in the input register and, unless
// it is a multiply or the result stream is stalled, executes in the cycle after it is accepted.
// Its result lands in the output register at the end of that cycle. Throughput is one instruction
// per cycle while the result stream is not stalled, for every opcode except mulr and muli: the
// 64-bit product is formed from 32x32 partial products that are registered before the final
// sum, and the instruction stays in the input register until that sum is taken. A stalled
// result word holds the instruction behind it in the input register. Register reads, the ALU
// and write-back share one stage, so a following instruction always sees the previous result.
// The halted flag is only a report; execution goes on. Configuration writes are taken at any
// time but must only be issued while idle.
`default_nettype none

module six_register_instruction_executor (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration: 0 pointer_register, 1 program_length
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_addr,
    input  wire logic [15:0]                        cfg_wdata,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: opcode[3:0], operand_a[35:4], operand_b[67:36], operand_c[70:68], zero pad
    input  wire logic [sri_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: next_pointer[63:0], written_index[66:64], written_value[130:67],
    //        halted[131], bad_index[132], zero pad
    output logic      [sri_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import sri_pkg::*;

    // configuration registers
    logic [2:0]  ptr_sel_reg;
    logic [15:0] prog_len_reg;

    // input register
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [31:0] in_a_reg;
    logic [31:0] in_b_reg;
    logic [2:0]  in_c_reg;

    // multiply sequencing
    logic        mul_phase_reg;
    logic        mul_load;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] np_reg;
    logic [2:0]        widx_reg;
    logic [DATA_W-1:0] wval_reg;
    logic              halted_reg;
    logic              bad_reg;

    // datapath
    logic              exec_fire;
    logic              in_free;
    logic [DATA_W-1:0] rd_a_data;
    logic [DATA_W-1:0] rd_b_data;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W-1:0] mul_product;
    logic [DATA_W-1:0] result;
    logic [2:0]        dest;
    logic              bad;
    logic              ptr_ok;
    logic [DATA_W-1:0] ptr_value;
    logic [DATA_W-1:0] next_ptr;
    logic              halted;
    commit_t           commit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_sel_reg  <= 3'd0;
            prog_len_reg <= 16'd32;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_POINTER_REGISTER: ptr_sel_reg  <= cfg_wdata[2:0];
                CFG_PROGRAM_LENGTH:   prog_len_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // handshake control
    assign exec_fire = in_valid_reg && (!is_mul(in_op_reg) || mul_phase_reg)
                       && (!m_valid_reg || m_axis_tready);
    assign mul_load  = in_valid_reg && is_mul(in_op_reg) && !mul_phase_reg;
    assign in_free   = !in_valid_reg || exec_fire;
    assign s_axis_tready = in_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_axis_tvalid) begin
            in_op_reg <= op_t'(s_axis_tdata[3:0]);
            in_a_reg  <= s_axis_tdata[35:4];
            in_b_reg  <= s_axis_tdata[67:36];
            in_c_reg  <= s_axis_tdata[70:68];
        end
    end

    // multiply phase: set once the partial products are loaded, cleared when the result fires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_phase_reg <= 1'b0;
        end else if (exec_fire) begin
            mul_phase_reg <= 1'b0;
        end else if (mul_load) begin
            mul_phase_reg <= 1'b1;
        end
    end

    sri_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_a_idx  (REG_IDX_W'(in_a_reg)),
        .rd_b_idx  (REG_IDX_W'(in_b_reg)),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .commit    (commit),
        .wr_data   (result),
        .ptr_value (ptr_value)
    );

    sri_mul u_mul (
        .aclk    (aclk),
        .load    (mul_load),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (mul_product)
    );

    sri_alu u_alu (
        .op          (in_op_reg),
        .operand_a   (in_a_reg),
        .operand_b   (in_b_reg),
        .operand_c   (in_c_reg),
        .rd_a_data   (rd_a_data),
        .rd_b_data   (rd_b_data),
        .mul_product (mul_product),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .result      (result),
        .dest        (dest),
        .bad         (bad)
    );

    // write-back and pointer update
    always_comb begin
        ptr_ok         = {29'd0, ptr_sel_reg} < NUM_REGS_U;
        commit.fire    = exec_fire;
        commit.wr_en   = !bad;
        commit.wr_idx  = REG_IDX_W'(dest);
        commit.ptr_en  = ptr_ok;
        commit.ptr_idx = REG_IDX_W'(ptr_sel_reg);
        next_ptr       = ptr_ok ? ptr_value : '0;
        halted         = next_ptr[DATA_W-1] || (next_ptr >= {48'd0, prog_len_reg});
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            np_reg     <= next_ptr;
            widx_reg   <= dest;
            wval_reg   <= result;
            halted_reg <= halted;
            bad_reg    <= bad;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'd0, bad_reg, halted_reg, wval_reg, widx_reg, np_reg};

endmodule

`default_nettype wire
